[hw/rtl/pes_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the pairwise eta-squared block.
// Depends on nothing; every other file of the block imports it.
package pes_pkg;

  localparam int COUNT_W     = 13;
  localparam int SUM_W       = 29;
  localparam int SQ_W        = 44;
  localparam int DSQ_W       = 46;
  localparam int ETA_W       = 17;
  localparam int COUNT_MAX   = 2 ** COUNT_W - 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_STEPS   = 18;
  localparam int Q_W         = 18;

  localparam logic [ETA_W-1:0] ONE_Q16 = 17'd65536;

  typedef struct packed {
    logic signed [15:0] sample_a;
    logic signed [15:0] sample_b;
    logic               last;
  } pes_in_t;

  typedef struct packed {
    logic [ETA_W-1:0] eta;
    logic             degenerate;
  } pes_out_t;

  // Totals of one vector pair, handed from the accumulator to the finisher.
  typedef struct packed {
    logic [COUNT_W-1:0] pair_count;
    logic [SUM_W-1:0]   sum_first;
    logic [SUM_W-1:0]   sum_second;
    logic [SQ_W-1:0]    sum_squares;
    logic [DSQ_W-1:0]   sum_diff_squares;
  } pes_snap_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pes_qstat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DRAIN,
    ST_SUB,
    ST_CLAMP,
    ST_DIV,
    ST_WRITE
  } pes_state_t;

endpackage

[hw/rtl/pes_front.sv]
`timescale 1ns / 1ps
// Front end: accepts element pairs, squares them and keeps saturating totals.
// Uses pes_pkg; hands each finished vector's totals to the snapshot queue.
module pes_front import pes_pkg::*; #(
  parameter int MAX_LENGTH = 4096
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  pes_in_t    item,
  output logic       full,
  output logic       q_push,
  output pes_snap_t  snap,
  input  pes_qstat_t qstat
);

  localparam int COUNT_LIMIT = (MAX_LENGTH < COUNT_MAX) ? MAX_LENGTH : COUNT_MAX;

  // Square stage
  logic               s1_valid;
  logic               s1_last;
  logic signed [15:0] s1_a;
  logic signed [15:0] s1_b;
  logic [30:0]        s1_aa;
  logic [30:0]        s1_bb;
  logic [31:0]        s1_dd;

  // Running totals
  logic [COUNT_W-1:0] pair_count;
  logic [SUM_W-1:0]   sum_first;
  logic [SUM_W-1:0]   sum_second;
  logic [SQ_W-1:0]    sum_squares;
  logic [DSQ_W-1:0]   sum_diff_squares;

  logic               adv;
  logic               accept;
  logic               cnt_ok;
  logic signed [16:0] d_in;
  logic signed [31:0] aa_full;
  logic signed [31:0] bb_full;
  logic signed [33:0] dd_full;
  logic [SUM_W:0]     sf_wide;
  logic [SUM_W:0]     ss_wide;
  logic [31:0]        sq_add;
  logic [SQ_W:0]      sq_wide;
  logic [DSQ_W:0]     dsq_wide;
  pes_snap_t          tot_next;

  // The square stage holds only when a final pair finds the queue full.
  assign adv    = !(s1_valid && s1_last && qstat.full);
  assign full   = s1_valid && !adv;
  assign accept = push && !full;
  assign q_push = s1_valid && s1_last && adv;
  assign snap   = tot_next;

  assign d_in    = {item.sample_a[15], item.sample_a} - {item.sample_b[15], item.sample_b};
  assign aa_full = item.sample_a * item.sample_a;
  assign bb_full = item.sample_b * item.sample_b;
  assign dd_full = d_in * d_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last <= item.last;
      s1_a    <= item.sample_a;
      s1_b    <= item.sample_b;
      s1_aa   <= aa_full[30:0];
      s1_bb   <= bb_full[30:0];
      s1_dd   <= dd_full[31:0];
    end
  end

  always_comb begin
    cnt_ok   = 32'(pair_count) < COUNT_LIMIT;
    sf_wide  = {sum_first[SUM_W-1], sum_first} + {{(SUM_W-15){s1_a[15]}}, s1_a};
    ss_wide  = {sum_second[SUM_W-1], sum_second} + {{(SUM_W-15){s1_b[15]}}, s1_b};
    sq_add   = {1'b0, s1_aa} + {1'b0, s1_bb};
    sq_wide  = {1'b0, sum_squares} + (SQ_W+1)'(sq_add);
    dsq_wide = {1'b0, sum_diff_squares} + (DSQ_W+1)'(s1_dd);

    tot_next.pair_count       = pair_count;
    tot_next.sum_first        = sum_first;
    tot_next.sum_second       = sum_second;
    tot_next.sum_squares      = sum_squares;
    tot_next.sum_diff_squares = sum_diff_squares;
    if (cnt_ok) begin
      tot_next.pair_count = pair_count + 1'b1;
      // A signed sum has left its range when the two top bits disagree.
      if (sf_wide[SUM_W] != sf_wide[SUM_W-1]) begin
        tot_next.sum_first = {sf_wide[SUM_W], {(SUM_W-1){!sf_wide[SUM_W]}}};
      end else begin
        tot_next.sum_first = sf_wide[SUM_W-1:0];
      end
      if (ss_wide[SUM_W] != ss_wide[SUM_W-1]) begin
        tot_next.sum_second = {ss_wide[SUM_W], {(SUM_W-1){!ss_wide[SUM_W]}}};
      end else begin
        tot_next.sum_second = ss_wide[SUM_W-1:0];
      end
      tot_next.sum_squares      = sq_wide[SQ_W] ? '1 : sq_wide[SQ_W-1:0];
      tot_next.sum_diff_squares = dsq_wide[DSQ_W] ? '1 : dsq_wide[DSQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_count       <= '0;
      sum_first        <= '0;
      sum_second       <= '0;
      sum_squares      <= '0;
      sum_diff_squares <= '0;
    end else if (s1_valid && adv) begin
      if (s1_last) begin
        pair_count       <= '0;
        sum_first        <= '0;
        sum_second       <= '0;
        sum_squares      <= '0;
        sum_diff_squares <= '0;
      end else begin
        pair_count       <= tot_next.pair_count;
        sum_first        <= tot_next.sum_first;
        sum_second       <= tot_next.sum_second;
        sum_squares      <= tot_next.sum_squares;
        sum_diff_squares <= tot_next.sum_diff_squares;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(pair_count) <= COUNT_LIMIT)
    else $error("pair count has passed its limit");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_last && adv) |=> (pair_count == '0 && sum_squares == '0))
    else $error("totals not cleared after the final pair");

endmodule

[hw/rtl/pes_queue.sv]
`timescale 1ns / 1ps
// Short queue of per-vector totals between the accumulator and the finisher.
// Uses pes_pkg for the snapshot type and its depth.
module pes_queue import pes_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  pes_snap_t  snap_in,
  input  logic       pop,
  output pes_snap_t  snap_out,
  output pes_qstat_t qstat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  pes_snap_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign qstat.full  = count == CNT_W'(QUEUE_DEPTH);
  assign qstat.empty = count == '0;
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign snap_out    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= snap_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= QUEUE_DEPTH)
    else $error("snapshot queue holds more than its depth");

endmodule

[hw/rtl/pes_back.sv]
`timescale 1ns / 1ps
// Back end: forms the spread terms with one shared multiplier, divides
// bit by bit and holds the result for the consumer. Uses pes_pkg.
module pes_back import pes_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  pes_snap_t  snap,
  input  pes_qstat_t qstat,
  output logic       snap_take,
  input  logic       pop,
  output logic       empty,
  output pes_out_t   result
);

  localparam int MUL_W  = 30;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 62;
  localparam int RACC_W = 59;
  localparam int DEN_W  = 58;
  localparam int STEP_W = 3;
  localparam int DCNT_W = $clog2(DIV_STEPS);

  localparam logic [STEP_W-1:0] STEP_SQ_LO = 3'd0;
  localparam logic [STEP_W-1:0] STEP_SQ_HI = 3'd1;
  localparam logic [STEP_W-1:0] STEP_SS    = 3'd2;
  localparam logic [STEP_W-1:0] STEP_D_LO  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_D_HI  = 3'd4;

  pes_state_t        state;
  pes_state_t        state_next;
  pes_snap_t         snap_r;
  logic [MUL_W-1:0]  abs_s;
  logic [STEP_W-1:0] step;
  logic [PROD_W-1:0] prod;
  logic [STEP_W-1:0] prod_tag;
  logic              prod_vld;
  logic [ACC_W-1:0]  den_acc;
  logic [RACC_W-1:0] r_acc;
  logic [ACC_W-1:0]  num_raw;
  logic              degen_r;
  logic [DEN_W-1:0]  den_u;
  logic [DEN_W-1:0]  rem;
  logic [Q_W-1:0]    q;
  logic [DCNT_W-1:0] div_cnt;
  logic              res_valid;
  pes_out_t          result_r;

  logic              res_load;
  logic              slot_free;
  logic [MUL_W-1:0]  s_sum;
  logic [MUL_W-1:0]  s_abs;
  logic [MUL_W-1:0]  op_a;
  logic [MUL_W-1:0]  op_b;
  logic [PROD_W-1:0] prod_next;
  logic [ACC_W-1:0]  den_acc_next;
  logic [RACC_W-1:0] r_acc_next;
  logic [DEN_W:0]    t_shift;
  logic [DEN_W:0]    t_sub;
  logic              t_ge;
  logic [DEN_W-1:0]  num_clamped;
  logic [Q_W:0]      q_round;
  logic [ETA_W-1:0]  eta_val;

  assign slot_free = !res_valid || pop;
  assign empty     = !res_valid;
  assign result    = result_r;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (!qstat.empty) state_next = ST_MUL;
      ST_MUL:   if (step == STEP_D_HI) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_SUB;
      ST_SUB:   state_next = ST_CLAMP;
      ST_CLAMP: state_next = degen_r ? ST_WRITE : ST_DIV;
      ST_DIV:   if (div_cnt == DCNT_W'(DIV_STEPS - 1)) state_next = ST_WRITE;
      ST_WRITE: if (slot_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    snap_take = 1'b0;
    res_load  = 1'b0;
    unique case (state)
      ST_IDLE:  snap_take = !qstat.empty;
      ST_WRITE: res_load  = slot_free;
      default: begin
        snap_take = 1'b0;
        res_load  = 1'b0;
      end
    endcase
  end

  // The sum of all elements, and its magnitude for squaring.
  always_comb begin
    s_sum = {snap.sum_first[SUM_W-1], snap.sum_first}
          + {snap.sum_second[SUM_W-1], snap.sum_second};
    s_abs = s_sum[MUL_W-1] ? MUL_W'(0) - s_sum : s_sum;
  end

  // 2*n*SQ and n*D are split into halves so that each product stays narrow.
  always_comb begin
    case (step)
      STEP_SQ_LO: begin
        op_a = MUL_W'(snap_r.pair_count);
        op_b = MUL_W'(snap_r.sum_squares[21:0]);
      end
      STEP_SQ_HI: begin
        op_a = MUL_W'(snap_r.pair_count);
        op_b = MUL_W'(snap_r.sum_squares[43:22]);
      end
      STEP_SS: begin
        op_a = abs_s;
        op_b = abs_s;
      end
      STEP_D_LO: begin
        op_a = MUL_W'(snap_r.pair_count);
        op_b = MUL_W'(snap_r.sum_diff_squares[22:0]);
      end
      STEP_D_HI: begin
        op_a = MUL_W'(snap_r.pair_count);
        op_b = MUL_W'(snap_r.sum_diff_squares[45:23]);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    prod_next = op_a * op_b;
  end

  always_comb begin
    den_acc_next = den_acc;
    r_acc_next   = r_acc;
    if (prod_vld) begin
      case (prod_tag)
        STEP_SQ_LO: den_acc_next = den_acc + (ACC_W'(prod) << 1);
        STEP_SQ_HI: den_acc_next = den_acc + (ACC_W'(prod) << 23);
        STEP_SS:    den_acc_next = den_acc - ACC_W'(prod);
        STEP_D_LO:  r_acc_next   = r_acc + RACC_W'(prod);
        STEP_D_HI:  r_acc_next   = r_acc + (RACC_W'(prod) << 23);
        default: begin
          den_acc_next = den_acc;
          r_acc_next   = r_acc;
        end
      endcase
    end
  end

  // Numerator is clamped to 0..den before the division.
  always_comb begin
    if (num_raw[ACC_W-1]) begin
      num_clamped = '0;
    end else if (num_raw > ACC_W'(den_u)) begin
      num_clamped = den_u;
    end else begin
      num_clamped = num_raw[DEN_W-1:0];
    end
  end

  // One restoring step per cycle; the first step compares without a shift.
  always_comb begin
    t_shift = (div_cnt == '0) ? {1'b0, rem} : {rem, 1'b0};
    t_ge    = t_shift >= {1'b0, den_u};
    t_sub   = t_shift - {1'b0, den_u};
  end

  always_comb begin
    q_round = {1'b0, q} + (Q_W+1)'(1);
    if (q_round[Q_W:1] > Q_W'(ONE_Q16)) begin
      eta_val = ONE_Q16;
    end else begin
      eta_val = q_round[ETA_W:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      prod_vld  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state    <= state_next;
      prod_vld <= state == ST_MUL;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (snap_take) begin
          snap_r  <= snap;
          abs_s   <= s_abs;
          step    <= STEP_SQ_LO;
          den_acc <= '0;
          r_acc   <= '0;
        end
      end
      ST_MUL: begin
        prod     <= prod_next;
        prod_tag <= step;
        step     <= step + 1'b1;
        den_acc  <= den_acc_next;
        r_acc    <= r_acc_next;
      end
      ST_DRAIN: begin
        den_acc <= den_acc_next;
        r_acc   <= r_acc_next;
      end
      ST_SUB: begin
        num_raw <= den_acc - ACC_W'(r_acc);
        degen_r <= den_acc[ACC_W-1] || (den_acc == '0);
        den_u   <= den_acc[DEN_W-1:0];
      end
      ST_CLAMP: begin
        rem     <= num_clamped;
        q       <= '0;
        div_cnt <= '0;
      end
      ST_DIV: begin
        rem     <= t_ge ? t_sub[DEN_W-1:0] : t_shift[DEN_W-1:0];
        q       <= {q[Q_W-2:0], t_ge};
        div_cnt <= div_cnt + 1'b1;
      end
      ST_WRITE: begin
        if (res_load) begin
          result_r.eta        <= degen_r ? '0 : eta_val;
          result_r.degenerate <= degen_r;
        end
      end
      default: begin
      end
    endcase
  end

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.degenerate) |-> (result.eta == '0))
    else $error("degenerate result carries a nonzero coefficient");

  a_eta_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.eta <= ONE_Q16))
    else $error("coefficient above one");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_cnt != '0) |-> (rem < den_u))
    else $error("division remainder not below the divisor");

endmodule

[hw/rtl/pairwise_eta_squared.sv]
`timescale 1ns / 1ps
// Eta-squared similarity of two vectors streamed as element pairs.
// Throughput: one pair per cycle; the finisher handles one vector's totals at a time, so
// a two-deep totals queue lets short vectors stall the input while it is full.
// Each result passes the five-step shared multiplier, the subtract and clamp, and the
// 18-step divider, which is skipped when the spread is zero.
// Reset (synchronous) clears totals, queue and result; there is no sweep.
module pairwise_eta_squared import pes_pkg::*; #(
  parameter int MAX_LENGTH = 4096
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  pes_in_t  item,
  output logic     empty,
  input  logic     pop,
  output pes_out_t result
);

  logic       q_push;
  logic       snap_take;
  pes_snap_t  snap_in;
  pes_snap_t  snap_out;
  pes_qstat_t qstat;

  pes_front #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .q_push (q_push),
    .snap   (snap_in),
    .qstat  (qstat)
  );

  pes_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .snap_in  (snap_in),
    .pop      (snap_take),
    .snap_out (snap_out),
    .qstat    (qstat)
  );

  pes_back u_back (
    .clk       (clk),
    .rst       (rst),
    .snap      (snap_out),
    .qstat     (qstat),
    .snap_take (snap_take),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

endmodule
